### sv/archive_table_crypt_hash_assert.svh
// Assertion macros shared by the crypt table and hash/decrypt datapath.
`ifndef ARCHIVE_TABLE_CRYPT_HASH_ASSERT_SVH
`define ARCHIVE_TABLE_CRYPT_HASH_ASSERT_SVH

// Checked only outside reset.
`define ATCH_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define ATCH_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

### sv/atch_pkg.sv
// Types and constants of the archive crypt table hash/decrypt block.
package atch_pkg;

  localparam int TableDepth = 1280;
  localparam int TableAw    = 11;

  // Table generator: seed = (seed * 125 + 3) mod 0x2AAAAB
  localparam logic [21:0] GenStart = 22'h100001;
  localparam logic [21:0] GenMod   = 22'h2AAAAB;
  localparam logic [28:0] GenMul   = 29'd125;
  localparam logic [28:0] GenInc   = 29'd3;
  localparam int          GenShift = 51;
  // floor(2^51 / mod): quotient estimate is low by at most one
  localparam logic [29:0] GenRecip = 30'((64'd1 << GenShift) / 64'(GenMod));
  localparam logic [2:0]  LastRow  = 3'd4;
  localparam logic [7:0]  LastCol  = 8'hFF;

  localparam logic [31:0] HashStartOne = 32'h7FED7FED;
  localparam logic [31:0] SeedStartTwo = 32'hEEEEEEEE;
  localparam logic [31:0] KeyAdd       = 32'h11111111;
  localparam logic [31:0] MixInc       = 32'd3;
  localparam int          MixShl       = 5;
  localparam int          KeyShl       = 21;
  localparam int          KeyShr       = 11;
  localparam logic [TableAw-1:0] KeyMixBase = 11'h400;

  localparam logic [7:0] CharLowA   = 8'h61;
  localparam logic [7:0] CharLowZ   = 8'h7A;
  localparam logic [7:0] CaseOffset = 8'h20;

  typedef enum logic {
    OP_HASH    = 1'b0,
    OP_DECRYPT = 1'b1
  } op_e;

  typedef enum logic {
    KIND_WORD = 1'b0,
    KIND_HASH = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    GEN_MUL,
    GEN_QUO,
    GEN_RED,
    GEN_DONE
  } gen_state_e;

  // Table read port request from the datapath.
  typedef struct packed {
    logic               en;
    logic [TableAw-1:0] addr;
  } tbl_rd_t;

endpackage

### sv/atch_if.sv
// Request and result stream interfaces of the hash/decrypt block.
interface atch_in_if;
  import atch_pkg::*;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] data_word;
  logic [1:0]  hash_type;
  logic [31:0] block_key;
  logic        first_item;
  logic        last_item;

  modport source (output valid, operation, data_word, hash_type, block_key,
                  first_item, last_item, input ready);
  modport sink (input valid, operation, data_word, hash_type, block_key,
                first_item, last_item, output ready);
endinterface

interface atch_out_if;
  import atch_pkg::*;
  logic        valid;
  logic        ready;
  logic [31:0] result_word;
  logic        result_kind;

  modport source (output valid, result_word, result_kind, input ready);
  modport sink (input valid, result_word, result_kind, output ready);
endinterface

### sv/atch_table.sv
// Crypt table memory with its power-up fill sequencer.
`include "archive_table_crypt_hash_assert.svh"

module atch_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  atch_pkg::tbl_rd_t rd_i,
  output logic [31:0]       rdata_o,
  output logic              ready_o
);
  import atch_pkg::*;

  logic [31:0] mem_q [TableDepth];
  logic [31:0] rdata_q;

  gen_state_e  state_q, state_d;
  logic [21:0] seed_q, seed_d;
  logic [28:0] x_q, x_d;
  logic [6:0]  quo_q, quo_d;
  logic        half_q, half_d;
  logic [15:0] hi_q, hi_d;
  logic [7:0]  col_q, col_d;
  logic [2:0]  row_q, row_d;

  logic               wr_en;
  logic [TableAw-1:0] wr_addr;
  logic [31:0]        wr_data;
  logic [58:0]        quo_prod;
  logic [28:0]        rem_raw;
  logic [21:0]        seed_new;

  always_comb begin
    quo_prod = {30'd0, x_q} * {29'd0, GenRecip};
    rem_raw  = x_q - 29'({22'd0, quo_q} * {7'd0, GenMod});
    // estimate may be one low: one correcting subtract
    seed_new = (rem_raw >= 29'(GenMod)) ? 22'(rem_raw - 29'(GenMod)) : rem_raw[21:0];
    wr_addr  = {row_q, col_q};
    wr_data  = {hi_q, seed_new[15:0]};
  end

  always_comb begin
    state_d = state_q;
    seed_d  = seed_q;
    x_d     = x_q;
    quo_d   = quo_q;
    half_d  = half_q;
    hi_d    = hi_q;
    col_d   = col_q;
    row_d   = row_q;
    wr_en   = 1'b0;
    unique case (state_q)
      GEN_MUL: begin
        x_d     = {7'd0, seed_q} * GenMul + GenInc;
        state_d = GEN_QUO;
      end
      GEN_QUO: begin
        quo_d   = quo_prod[GenShift+6:GenShift];
        state_d = GEN_RED;
      end
      GEN_RED: begin
        seed_d  = seed_new;
        state_d = GEN_MUL;
        if (!half_q) begin
          hi_d   = seed_new[15:0];
          half_d = 1'b1;
        end else begin
          wr_en  = 1'b1;
          half_d = 1'b0;
          if (row_q == LastRow) begin
            row_d = 3'd0;
            if (col_q == LastCol) begin
              state_d = GEN_DONE;
            end else begin
              col_d = col_q + 8'd1;
            end
          end else begin
            row_d = row_q + 3'd1;
          end
        end
      end
      GEN_DONE: begin
        state_d = GEN_DONE;
      end
      default: begin
        state_d = GEN_MUL;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= GEN_MUL;
      seed_q  <= GenStart;
      half_q  <= 1'b0;
      col_q   <= 8'd0;
      row_q   <= 3'd0;
    end else begin
      state_q <= state_d;
      seed_q  <= seed_d;
      half_q  <= half_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    quo_q <= quo_d;
    hi_q  <= hi_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_i.en) begin
      rdata_q <= mem_q[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;
  assign ready_o = (state_q == GEN_DONE);

  `ATCH_ASSERT(a_fill_done_stays, (state_q == GEN_DONE) |=> (state_q == GEN_DONE), "table fill state left done")
  `ATCH_ASSERT_RST(a_read_after_fill, rd_i.en |-> (state_q == GEN_DONE), "table read before fill finished")
  `ATCH_ASSERT(a_write_second_half, wr_en |-> half_q, "table write without upper half")

endmodule

### sv/atch_core.sv
// Hash and decrypt datapath: table read at accept, then update and registered result.
`include "archive_table_crypt_hash_assert.svh"

module atch_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  atch_in_if.sink           in_i,
  atch_out_if.source        out_o,
  input  logic              tbl_ready_i,
  input  logic [31:0]       tbl_rdata_i,
  output atch_pkg::tbl_rd_t rd_o
);
  import atch_pkg::*;

  typedef struct packed {
    op_e         op;
    logic [7:0]  ch;
    logic [31:0] word;
    logic [31:0] key1;
    logic        first;
    logic        last;
  } pipe_t;

  pipe_t       p_q, p_d;
  logic        p_valid_q, p_valid_d;
  logic [31:0] key1_q, key1_d;
  logic [31:0] seed1_q, seed1_d;
  logic [31:0] seed2_q, seed2_d;
  logic [31:0] key2_q, key2_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_word_q, out_word_d;
  kind_e       out_kind_q, out_kind_d;

  logic        accept;
  logic        p_adv;
  logic        produce;
  logic [7:0]  ch_raw;
  logic [7:0]  ch_up;
  logic [31:0] key1_cur;
  logic [31:0] s1_cur, s2_cur, s1_new, s2_new;
  logic [31:0] k2_cur, k2_mix, plain;

  // Request stage: case fold, table address, key one advance
  always_comb begin
    ch_raw   = in_i.data_word[7:0];
    ch_up    = ((ch_raw >= CharLowA) && (ch_raw <= CharLowZ)) ? ch_raw - CaseOffset : ch_raw;
    key1_cur = in_i.first_item ? in_i.block_key : key1_q;
    accept   = in_i.valid && in_i.ready;

    p_d.op    = op_e'(in_i.operation);
    p_d.ch    = ch_up;
    p_d.word  = in_i.data_word;
    p_d.key1  = key1_cur;
    p_d.first = in_i.first_item;
    p_d.last  = in_i.last_item;

    rd_o.en = accept;
    if (in_i.operation == OP_DECRYPT) begin
      rd_o.addr = KeyMixBase + {3'd0, key1_cur[7:0]};
    end else begin
      rd_o.addr = {1'b0, in_i.hash_type, ch_up};
    end

    key1_d = key1_q;
    if (accept && (in_i.operation == OP_DECRYPT)) begin
      key1_d = ((~key1_cur << KeyShl) + KeyAdd) | (key1_cur >> KeyShr);
    end
  end

  // Update stage: table word is here, seeds and key two chain item to item
  always_comb begin
    s1_cur = p_q.first ? HashStartOne : seed1_q;
    s2_cur = p_q.first ? SeedStartTwo : seed2_q;
    s1_new = tbl_rdata_i ^ (s1_cur + s2_cur);
    s2_new = {24'd0, p_q.ch} + s1_new + s2_cur + (s2_cur << MixShl) + MixInc;

    k2_cur = p_q.first ? SeedStartTwo : key2_q;
    k2_mix = k2_cur + tbl_rdata_i;
    plain  = p_q.word ^ (p_q.key1 + k2_mix);

    produce = (p_q.op == OP_DECRYPT) || p_q.last;
    p_adv   = p_valid_q && (!out_valid_q || out_o.ready || !produce);

    seed1_d = seed1_q;
    seed2_d = seed2_q;
    key2_d  = key2_q;
    if (p_adv) begin
      if (p_q.op == OP_DECRYPT) begin
        key2_d = plain + k2_mix + (k2_mix << MixShl) + MixInc;
      end else begin
        seed1_d = s1_new;
        seed2_d = s2_new;
      end
    end

    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    out_kind_d  = out_kind_q;
    if (p_adv && produce) begin
      out_valid_d = 1'b1;
      out_word_d  = (p_q.op == OP_DECRYPT) ? plain : s1_new;
      out_kind_d  = (p_q.op == OP_DECRYPT) ? KIND_WORD : KIND_HASH;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (accept) begin
      p_valid_d = 1'b1;
    end else if (p_adv) begin
      p_valid_d = 1'b0;
    end else begin
      p_valid_d = p_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      key1_q      <= 32'd0;
      key2_q      <= SeedStartTwo;
      seed1_q     <= HashStartOne;
      seed2_q     <= SeedStartTwo;
    end else begin
      p_valid_q   <= p_valid_d;
      out_valid_q <= out_valid_d;
      key1_q      <= key1_d;
      key2_q      <= key2_d;
      seed1_q     <= seed1_d;
      seed2_q     <= seed2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_q <= p_d;
    end
    out_word_q <= out_word_d;
    out_kind_q <= out_kind_d;
  end

  assign in_i.ready        = tbl_ready_i && (!p_valid_q || p_adv);
  assign out_o.valid       = out_valid_q;
  assign out_o.result_word = out_word_q;
  assign out_o.result_kind = out_kind_q;

  `ATCH_ASSERT(a_accept_after_fill, (in_i.valid && in_i.ready) |-> tbl_ready_i, "request taken before table fill")
  `ATCH_ASSERT(a_stall_holds_stage, (p_valid_q && !p_adv) |=> p_valid_q, "stalled request dropped")
  `ATCH_ASSERT(a_decrypt_gives_result, (p_adv && (p_q.op == OP_DECRYPT)) |=> out_valid_q, "decrypt request gave no result")

endmodule

### sv/archive_table_crypt_hash.sv
// Top level of the archive crypt table name hash and word decrypt block.
//
// Usage:
//  - in_i carries one request per valid/ready handshake: a name character to
//    hash (operation 0) or a 32-bit word to decrypt (operation 1).
//  - out_o returns at most one result per request: the plain word for every
//    decrypt request, the finished 32-bit hash for a character with last_item.
//  - Path: the table is read at the accept edge; the seed/key update then
//    writes the result into the output register when the update stage
//    advances, which a held out_o can delay.
//  - Throughput: one request per cycle while out_o takes results. The table
//    index of each request is formed from the request itself (hash) or from
//    key one, which advances at accept time (decrypt), so the registered table
//    read overlaps the seed and key two update of the request before.
//  - Reset: rst_ni clears the seeds and keys to their start values and
//    starts the table fill. Each generator step passes the multiply,
//    quotient and reduce states, two steps per word for the 1280 words;
//    in_i.ready stays low until it finishes.
//  - Stall: while out_o is not taken, one more result-giving request can be
//    held in the update stage; in_i.ready then drops until the result leaves.
module archive_table_crypt_hash (
  input  logic       clk_i,
  input  logic       rst_ni,
  atch_in_if.sink    in_i,
  atch_out_if.source out_o
);
  import atch_pkg::*;

  tbl_rd_t     tbl_rd;
  logic [31:0] tbl_rdata;
  logic        tbl_ready;

  // crypt table memory, filled after reset
  atch_table u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_i    (tbl_rd),
    .rdata_o (tbl_rdata),
    .ready_o (tbl_ready)
  );

  // two-stage hash/decrypt datapath
  atch_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .tbl_ready_i (tbl_ready),
    .tbl_rdata_i (tbl_rdata),
    .rd_o        (tbl_rd)
  );

endmodule

### tb/atch_result_checker.sv
// Result checker for archive_table_crypt_hash: predicts hashes and plain words, compares outputs.
`timescale 1ns / 100ps

module atch_result_checker (
  input  logic clk_i,
  input  logic rst_ni,
  atch_in_if   in_mon,
  atch_out_if  out_mon,
  output int   fails_o,
  output int   pending_o,
  output int   requests_o,
  output int   hashes_o,
  output int   words_o
);
  import atch_pkg::*;

  localparam logic [63:0] GenFirst   = 64'h0010_0001;
  localparam logic [63:0] GenModulus = 64'h002A_AAAB;
  localparam logic [31:0] SeedOne    = 32'h7FED_7FED;
  localparam logic [31:0] SeedTwo    = 32'hEEEE_EEEE;
  localparam logic [31:0] KeyStep    = 32'h1111_1111;
  localparam int          MixRow     = 1024;

  typedef struct packed {
    logic [31:0] word;
    kind_e       kind;
  } result_t;

  logic [31:0] crypt_tbl [0:1279];
  logic [31:0] name_seed_a, name_seed_b;
  logic [31:0] block_key_a, block_key_b;
  result_t     due_results [$];
  int          fails = 0;
  int          requests = 0;
  int          hashes = 0;
  int          words = 0;

  // Column-major fill, two generator steps per word (high half first).
  function automatic void build_crypt_table();
    logic [63:0] gen;
    logic [15:0] hi;
    gen = GenFirst;
    for (int col = 0; col < 256; col++) begin
      for (int row = 0; row < 5; row++) begin
        gen = (gen * 64'd125 + 64'd3) % GenModulus;
        hi  = gen[15:0];
        gen = (gen * 64'd125 + 64'd3) % GenModulus;
        crypt_tbl[row * 256 + col] = {hi, gen[15:0]};
      end
    end
  endfunction

  initial build_crypt_table();

  // One name character; returns the running hash (seed A).
  function automatic logic [31:0] hash_char(input logic [7:0] c, input logic [1:0] row,
                                            input logic first);
    logic [7:0] up;
    up = c;
    if (c >= 8'h61 && c <= 8'h7A) up = c - 8'h20;
    if (first) begin
      name_seed_a = SeedOne;
      name_seed_b = SeedTwo;
    end
    name_seed_a = crypt_tbl[{row, up}] ^ (name_seed_a + name_seed_b);
    name_seed_b = {24'd0, up} + name_seed_a + name_seed_b + (name_seed_b << 5) + 32'd3;
    return name_seed_a;
  endfunction

  // One cipher word; returns the plain word.
  function automatic logic [31:0] decrypt_word(input logic [31:0] cipher,
                                               input logic [31:0] start_key,
                                               input logic first);
    logic [31:0] plain;
    if (first) begin
      block_key_a = start_key;
      block_key_b = SeedTwo;
    end
    block_key_b = block_key_b + crypt_tbl[MixRow + block_key_a[7:0]];
    plain       = cipher ^ (block_key_a + block_key_b);
    block_key_a = (((~block_key_a) << 21) + KeyStep) | (block_key_a >> 11);
    block_key_b = plain + block_key_b + (block_key_b << 5) + 32'd3;
    return plain;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t got, want;
    if (!rst_ni) begin
      name_seed_a = SeedOne;
      name_seed_b = SeedTwo;
      block_key_a = '0;
      block_key_b = SeedTwo;
      due_results.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        requests++;
        if (in_mon.operation == OP_DECRYPT) begin
          want.word = decrypt_word(in_mon.data_word, in_mon.block_key, in_mon.first_item);
          want.kind = KIND_WORD;
          due_results.push_back(want);
        end else begin
          want.word = hash_char(in_mon.data_word[7:0], in_mon.hash_type, in_mon.first_item);
          want.kind = KIND_HASH;
          if (in_mon.last_item) due_results.push_back(want);
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        got.word = out_mon.result_word;
        got.kind = kind_e'(out_mon.result_kind);
        if (due_results.size() == 0) begin
          if (fails < 10)
            $display("%0t: unexpected result word %h kind %0d", $realtime, got.word, got.kind);
          fails++;
        end else begin
          want = due_results.pop_front();
          if (got.kind === KIND_HASH) hashes++;
          else words++;
          if (got.word !== want.word || got.kind !== want.kind) begin
            if (fails < 10)
              $display("%0t: mismatch: expected word %h kind %0d, got word %h kind %0d",
                       $realtime, want.word, want.kind, got.word, got.kind);
            fails++;
          end
        end
      end
    end
    fails_o    <= fails;
    pending_o  <= due_results.size();
    requests_o <= requests;
    hashes_o   <= hashes;
    words_o    <= words;
  end

endmodule

### tb/tb.sv
// Testbench top for archive_table_crypt_hash: stimulus, stalls, watchdog and verdict.
`timescale 1ns / 100ps

module tb;
  import atch_pkg::*;

  // The table fill runs first; then ~710 requests follow, slowed by stalls.
  // The limit is many times the slowest plausible run.
  localparam int CycleLimit = 150000;
  localparam int PhaseReqs  = 230;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  atch_in_if  in_ch ();
  atch_out_if out_ch ();

  int fails, pending, requests, hashes, words;
  int send_idle_pct = 13;
  int recv_idle_pct = 71;
  int sent = 0;
  int cycles = 0;

  archive_table_crypt_hash DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  atch_result_checker checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fails_o    (fails),
    .pending_o  (pending),
    .requests_o (requests),
    .hashes_o   (hashes),
    .words_o    (words)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result ends here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("archive_table_crypt_hash test failed");
      $finish;
    end
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // One request. Random idle gap first (valid low), then hold until taken.
  task automatic send_req(input op_e op, input logic [31:0] data, input logic [1:0] row,
                          input logic [31:0] key, input logic first, input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= op;
    in_ch.data_word  <= data;
    in_ch.hash_type  <= row;
    in_ch.block_key  <= key;
    in_ch.first_item <= first;
    in_ch.last_item  <= last;
    do @(posedge clk_i); while (!in_ch.ready);
    sent++;
  endtask

  // Stop sending until every due result has come back. Waiting on the clock
  // first lets the checker's count include the request just taken.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Mostly path-like characters; some arbitrary bytes.
  function automatic logic [7:0] name_char();
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) return 8'h61 + 8'($urandom_range(25));   // a-z
    if (pick < 60) return 8'h41 + 8'($urandom_range(25));   // A-Z
    if (pick < 70) return 8'h2F;                            // slash
    if (pick < 80) return 8'h30 + 8'($urandom_range(9));    // digits
    if (pick < 85) return 8'h2E;                            // dot
    return 8'($urandom_range(255));
  endfunction

  // One random job: a name, a decrypt block, or a stray request.
  task automatic one_job();
    int          pick, len;
    logic [1:0]  row;
    logic [31:0] key, word;
    pick = $urandom_range(99);
    if (pick < 45) begin
      // Name of 1..12 chars; now and then a decrypt word slips in between,
      // and rarely the table row changes mid-name.
      len = $urandom_range(1, 12);
      row = 2'($urandom_range(3));
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(9) == 0)
          send_req(OP_DECRYPT, $urandom, 2'($urandom_range(3)), $urandom, 1'b0,
                   1'($urandom_range(1)));
        if ($urandom_range(19) == 0) row = 2'($urandom_range(3));
        word      = $urandom;
        word[7:0] = name_char();
        send_req(OP_HASH, word, row, $urandom, i == 0, i == len - 1);
      end
    end else if (pick < 85) begin
      // Decrypt block; unused fields carry junk.
      len = $urandom_range(1, 16);
      key = $urandom;
      for (int i = 0; i < len; i++)
        send_req(OP_DECRYPT, $urandom, 2'($urandom_range(3)), (i == 0) ? key : $urandom,
                 i == 0, 1'($urandom_range(1)));
    end else begin
      // Noise: every field random.
      send_req(op_e'($urandom_range(1)), $urandom, 2'($urandom_range(3)), $urandom,
               1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.operation  = OP_HASH;
    in_ch.data_word  = '0;
    in_ch.hash_type  = '0;
    in_ch.block_key  = '0;
    in_ch.first_item = 1'b0;
    in_ch.last_item  = 1'b0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Table fill runs now; the first request waits on in_ch.ready.

    // --- Directed ---
    // Keys and seeds straight from reset, no first flag; block_key ignored.
    send_req(OP_DECRYPT, 32'h0000_0000, 2'd0, 32'hFFFF_FFFF, 1'b0, 1'b0);
    // Lower-case char folds to upper; high bits of the word ignored.
    send_req(OP_HASH, 32'hFFFF_FF61, 2'd3, 32'hFFFF_FFFF, 1'b0, 1'b1);
    // One-char names at the byte extremes and around the a-z range, all rows.
    send_req(OP_HASH, 32'h0000_0000, 2'd0, 32'h0, 1'b1, 1'b1);
    send_req(OP_HASH, 32'h0000_00FF, 2'd1, 32'h0, 1'b1, 1'b1);
    send_req(OP_HASH, 32'h0000_0060, 2'd2, 32'h0, 1'b1, 1'b1);
    send_req(OP_HASH, 32'h0000_007B, 2'd3, 32'h0, 1'b1, 1'b1);
    send_req(OP_HASH, 32'h0000_0041, 2'd0, 32'h0, 1'b1, 1'b1);
    send_req(OP_HASH, 32'h0000_005A, 2'd1, 32'h0, 1'b1, 1'b1);
    send_req(OP_HASH, 32'h0000_007A, 2'd2, 32'h0, 1'b1, 1'b1);
    // "a/z" with decrypt blocks started in the middle; seeds must survive.
    send_req(OP_HASH,    32'h0000_0061, 2'd1, 32'h0,         1'b1, 1'b0);
    send_req(OP_DECRYPT, 32'hFFFF_FFFF, 2'd0, 32'h0000_0000, 1'b1, 1'b0);
    send_req(OP_HASH,    32'h0000_002F, 2'd1, 32'h0,         1'b0, 1'b0);
    send_req(OP_DECRYPT, 32'h0000_0000, 2'd3, 32'hFFFF_FFFF, 1'b1, 1'b1);
    send_req(OP_HASH,    32'h0000_007A, 2'd1, 32'h0,         1'b0, 1'b1);
    // Finished name continued without first.
    send_req(OP_HASH, 32'h0000_002E, 2'd1, 32'h0, 1'b0, 1'b1);
    // Block continued; block_key, hash_type and last ignored.
    send_req(OP_DECRYPT, 32'h1234_5678, 2'd0, 32'hDEAD_BEEF, 1'b0, 1'b0);
    send_req(OP_DECRYPT, 32'hFFFF_FFFF, 2'd2, 32'h0,         1'b0, 1'b1);
    // Key with only the top bit set.
    send_req(OP_DECRYPT, 32'hA5A5_A5A5, 2'd1, 32'h8000_0000, 1'b1, 1'b0);

    // --- Random, three stall profiles; drain between them ---
    for (int phase = 0; phase < 3; phase++) begin
      drain();
      case (phase)
        0: begin
          send_idle_pct = 13;
          recv_idle_pct = 71;
        end
        1: begin
          send_idle_pct = 71;
          recv_idle_pct = 13;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int target = sent + PhaseReqs; sent < target; ) one_job();
    end

    // Wait out everything due, then a margin past the result latency.
    drain();
    repeat (20) @(posedge clk_i);

    $display("Run covered %0d requests: names, decrypt blocks, interleaving and noise",
             requests);
    $display("Checked %0d name hashes and %0d plain words under three stall profiles",
             hashes, words);
    if (fails == 0) begin
      $display("archive_table_crypt_hash test passed");
    end else begin
      $display("archive_table_crypt_hash test failed");
    end
    $finish;
  end

endmodule
